FILE: design/multidim_array_index_linearizer_defines.svh
// Assertion macros for the array index linearizer RTL.
// Depends on nothing; included by files that check their own logic.
`ifndef MULTIDIM_ARRAY_INDEX_LINEARIZER_DEFINES_SVH
`define MULTIDIM_ARRAY_INDEX_LINEARIZER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define MDAL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define MDAL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: design/mdal_pkg.sv
// Types and status codes for the array index linearizer.
// Used by mdal_range_check and multidim_array_index_linearizer.
package mdal_pkg;

   localparam int OUT_OFFSET_W = 20;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   typedef struct packed {
      logic signed [63:0] range_left;
      logic signed [63:0] range_right;
      logic               descending;
      logic               null_range;
      logic signed [63:0] index_value;
      logic               last_dimension;
   } req_type;

   typedef struct packed {
      logic [OUT_OFFSET_W-1:0] linear_offset;
      logic [1:0]              status;
   } rsp_type;

   // Per-dimension check results handed to the fold stage.
   typedef struct packed {
      logic in_range;
      logic dist_big;
      logic span_big;
      logic last;
   } chk_type;

endpackage

FILE: design/mdal_range_check.sv
// Per-dimension range check: index containment, distance from left and span.
// Depends on mdal_pkg.
module mdal_range_check #(
   parameter int MAX_ELEMENTS = 1048576
) (
   input  mdal_pkg::req_type                     req,
   output mdal_pkg::chk_type                     chk,
   output logic [$clog2(MAX_ELEMENTS)-1:0]       dist_lo,
   output logic [$clog2(MAX_ELEMENTS)-1:0]       span_lo
);
   localparam int OFF_W = $clog2(MAX_ELEMENTS);

   logic        left_le_idx;
   logic        idx_le_right;
   logic        idx_le_left;
   logic        right_le_idx;
   logic [63:0] dist_full;
   logic [63:0] span;

   always_comb begin
      left_le_idx  = $signed(req.range_left)  <= $signed(req.index_value);
      idx_le_right = $signed(req.index_value) <= $signed(req.range_right);
      idx_le_left  = $signed(req.index_value) <= $signed(req.range_left);
      right_le_idx = $signed(req.range_right) <= $signed(req.index_value);

      if (req.descending) begin
         dist_full = 64'(req.range_left) - 64'(req.index_value);
         span      = 64'(req.range_left) - 64'(req.range_right);
      end else begin
         dist_full = 64'(req.index_value) - 64'(req.range_left);
         span      = 64'(req.range_right) - 64'(req.range_left);
      end

      chk.in_range = !req.null_range &&
                     (req.descending ? (idx_le_left && right_le_idx)
                                     : (left_le_idx && idx_le_right));
      chk.dist_big = dist_full >= 64'(MAX_ELEMENTS);
      chk.span_big = span >= 64'(MAX_ELEMENTS);
      chk.last     = req.last_dimension;
      dist_lo      = dist_full[OFF_W-1:0];
      span_lo      = span[OFF_W-1:0];
   end

endmodule

FILE: design/multidim_array_index_linearizer.sv
// An accepted last-dimension request passes the input, checked-dimension and response registers to its response.
// Throughput: one request per cycle while no response waits on rsp_ready; the running offset fold (one multiply-add
// and compare) closes its loop through the off_ff and err_ff registers.
// The whole pipeline holds while a response waits on rsp_ready.
// Reset (synchronous): clears all valids, the running offset and the latched error.
`include "multidim_array_index_linearizer_defines.svh"

module multidim_array_index_linearizer #(
   parameter int MAX_ELEMENTS = 1048576
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mdal_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mdal_pkg::rsp_type rsp_data
);
   localparam int OFF_W  = $clog2(MAX_ELEMENTS);
   localparam int PROD_W = 2 * OFF_W + 2;

   logic              enable;

   // input register
   logic              a_valid_ff, a_valid_in;
   mdal_pkg::req_type a_req_ff;

   // checked dimension
   mdal_pkg::chk_type a_chk;
   logic [OFF_W-1:0]  a_dist;
   logic [OFF_W-1:0]  a_span;
   logic              b_valid_ff, b_valid_in;
   mdal_pkg::chk_type b_chk_ff;
   logic [OFF_W-1:0]  b_dist_ff;
   logic [OFF_W-1:0]  b_span_ff;

   // fold state
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [1:0]        err_ff, err_in;
   logic [OFF_W-1:0]  fold_off;
   logic [1:0]        fold_err;
   logic [OFF_W:0]    span_p1;
   logic [PROD_W-1:0] next_sum;
   logic              fold_fire;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   mdal_pkg::rsp_type rsp_data_ff, rsp_data_in;

   assign enable    = !rsp_valid_ff || rsp_ready;
   assign req_ready = enable;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   mdal_range_check #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) u_check (
      .req     (a_req_ff),
      .chk     (a_chk),
      .dist_lo (a_dist),
      .span_lo (a_span)
   );

   assign span_p1   = {1'b0, b_span_ff} + (OFF_W+1)'(1);
   assign next_sum  = PROD_W'(off_ff) * PROD_W'(span_p1) + PROD_W'(b_dist_ff);
   assign fold_fire = b_valid_ff && enable;

   always_comb begin
      a_valid_in = enable ? req_valid : a_valid_ff;
      b_valid_in = enable ? a_valid_ff : b_valid_ff;

      fold_off = off_ff;
      fold_err = err_ff;
      if (err_ff == mdal_pkg::ST_OK) begin
         if (!b_chk_ff.in_range) begin
            fold_err = mdal_pkg::ST_INVALID;
         end else if (off_ff == '0) begin
            if (b_chk_ff.dist_big) begin
               fold_err = mdal_pkg::ST_OVERFLOW;
            end else begin
               fold_off = b_dist_ff;
            end
         end else if (b_chk_ff.span_big) begin
            fold_err = mdal_pkg::ST_OVERFLOW;
         end else if (next_sum >= PROD_W'(MAX_ELEMENTS)) begin
            fold_err = mdal_pkg::ST_OVERFLOW;
         end else begin
            fold_off = next_sum[OFF_W-1:0];
         end
      end

      off_in = off_ff;
      err_in = err_ff;
      if (fold_fire) begin
         if (b_chk_ff.last) begin
            off_in = '0;
            err_in = mdal_pkg::ST_OK;
         end else begin
            off_in = fold_off;
            err_in = fold_err;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (enable) begin
         rsp_valid_in = fold_fire && b_chk_ff.last;
         rsp_data_in.status = fold_err;
         rsp_data_in.linear_offset = (fold_err == mdal_pkg::ST_OK)
                                   ? mdal_pkg::OUT_OFFSET_W'(fold_off)
                                   : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         off_ff       <= '0;
         err_ff       <= mdal_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         off_ff       <= off_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && req_valid) begin
         a_req_ff <= req_data;
      end
      if (enable) begin
         b_chk_ff  <= a_chk;
         b_dist_ff <= a_dist;
         b_span_ff <= a_span;
      end
      rsp_data_ff <= rsp_data_in;
   end

   `MDAL_ASSERT_NOW(a_off_below_limit, clock, reset, 1'b1,
      off_ff < OFF_W'(MAX_ELEMENTS - 1) || off_ff == OFF_W'(MAX_ELEMENTS - 1))
   `MDAL_ASSERT_NOW(a_err_rsp_zero_offset, clock, reset,
      rsp_valid_ff && rsp_data_ff.status != mdal_pkg::ST_OK,
      rsp_data_ff.linear_offset == '0)
   `MDAL_ASSERT_NEXT(a_clear_after_last, clock, reset, fold_fire && b_chk_ff.last,
      off_ff == '0 && err_ff == mdal_pkg::ST_OK)
   `MDAL_ASSERT_NEXT(a_err_latched, clock, reset,
      err_ff != mdal_pkg::ST_OK && !(fold_fire && b_chk_ff.last), $stable(err_ff))

endmodule
